>>> rtl/core/box_box_separating_axis_test_core_defines.svh
// Assertion macros shared by the separating-axis test core.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BOX_BOX_SEPARATING_AXIS_TEST_CORE_DEFINES_SVH
`define BOX_BOX_SEPARATING_AXIS_TEST_CORE_DEFINES_SVH

// same-cycle implication
`define BBSAT_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BBSAT_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/bbsat_pkg.sv
// Fixed counts for the separating-axis test core: boxes, corners, axes, pipe depth.
// No dependencies.
package bbsat_pkg;

    localparam int BBSAT_NUM_BOXES       = 2;
    localparam int BBSAT_CORNERS_PER_BOX = 4;
    localparam int BBSAT_NUM_CORNERS     = BBSAT_NUM_BOXES * BBSAT_CORNERS_PER_BOX;
    localparam int BBSAT_NUM_AXES        = 4;
    localparam int BBSAT_PIPE_STAGES     = 6;

endpackage

>>> rtl/core/box_box_separating_axis_test_core.sv
// Overlap test of two oriented rectangles by separating axes, fully pipelined.
// Depends on bbsat_pkg and box_box_separating_axis_test_core_defines.svh.
//
// The core takes one pair of boxes per clock while s_ready is high and returns
// the overlap verdicts in order. The six register stages are: edge
// axes, 64 coordinate products (one multiplier each), projection sums, pairwise
// min/max, per-box min/max, and the interval compare. Each stage moves on when the
// stage after it is empty or moving, so bubbles close up and s_ready drops only
// when all six stages hold a transaction and m_ready is low. Arithmetic is exact.
`include "box_box_separating_axis_test_core_defines.svh"

module box_box_separating_axis_test_core
    import bbsat_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [2*COORD_WIDTH-1:0] s_box_a_corner0,
    input  logic [2*COORD_WIDTH-1:0] s_box_a_corner1,
    input  logic [2*COORD_WIDTH-1:0] s_box_a_corner2,
    input  logic [2*COORD_WIDTH-1:0] s_box_a_corner3,
    input  logic [2*COORD_WIDTH-1:0] s_box_b_corner0,
    input  logic [2*COORD_WIDTH-1:0] s_box_b_corner1,
    input  logic [2*COORD_WIDTH-1:0] s_box_b_corner2,
    input  logic [2*COORD_WIDTH-1:0] s_box_b_corner3,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_overlap
);

    localparam int CW   = COORD_WIDTH;
    localparam int AW   = CW + 1;       // axis component
    localparam int PW   = 2 * CW + 1;   // product
    localparam int SW   = 2 * CW + 2;   // projection
    localparam int LAST = BBSAT_PIPE_STAGES - 1;
    localparam int NC   = BBSAT_NUM_CORNERS;
    localparam int NA   = BBSAT_NUM_AXES;
    localparam int NB   = BBSAT_NUM_BOXES;
    localparam int CPB  = BBSAT_CORNERS_PER_BOX;

    // handshake / stage control
    logic [BBSAT_PIPE_STAGES-1:0] valid_reg;
    logic [BBSAT_PIPE_STAGES-1:0] valid_next;
    logic [BBSAT_PIPE_STAGES-1:0] stage_en;

    logic [2*CW-1:0] corner_in [NC];

    // stage 0
    logic signed [CW-1:0] xs_reg  [NC];
    logic signed [CW-1:0] ys_reg  [NC];
    logic signed [AW-1:0] axx_reg [NA];
    logic signed [AW-1:0] axy_reg [NA];
    // stage 1
    logic signed [PW-1:0] prodx_reg [NA][NC];
    logic signed [PW-1:0] prody_reg [NA][NC];
    // stage 2
    logic signed [SW-1:0] proj_reg [NA][NC];
    // stage 3
    logic signed [SW-1:0] pmin_reg [NA][NB][2];
    logic signed [SW-1:0] pmax_reg [NA][NB][2];
    // stage 4
    logic signed [SW-1:0] bmin_reg [NA][NB];
    logic signed [SW-1:0] bmax_reg [NA][NB];
    // stage 5
    logic                 overlap_reg;
    logic                 overlap_next;

    assign corner_in[0] = s_box_a_corner0;
    assign corner_in[1] = s_box_a_corner1;
    assign corner_in[2] = s_box_a_corner2;
    assign corner_in[3] = s_box_a_corner3;
    assign corner_in[4] = s_box_b_corner0;
    assign corner_in[5] = s_box_b_corner1;
    assign corner_in[6] = s_box_b_corner2;
    assign corner_in[7] = s_box_b_corner3;

    assign stage_en[LAST] = !valid_reg[LAST] || m_ready;
    for (genvar g = 0; g < LAST; g++) begin : g_en
        assign stage_en[g] = !valid_reg[g] || stage_en[g+1];
    end

    assign s_ready   = stage_en[0];
    assign m_valid   = valid_reg[LAST];
    assign m_overlap = overlap_reg;

    always_comb begin
        valid_next = valid_reg;
        if (stage_en[0]) begin
            valid_next[0] = s_valid;
        end
        for (int i = 1; i < BBSAT_PIPE_STAGES; i++) begin
            if (stage_en[i]) begin
                valid_next[i] = valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // stage 0: unpack corners, form edge axes c0-c1 and c2-c1 per box
    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            for (int c = 0; c < NC; c++) begin
                xs_reg[c] <= corner_in[c][2*CW-1:CW];
                ys_reg[c] <= corner_in[c][CW-1:0];
            end
            for (int b = 0; b < NB; b++) begin
                axx_reg[2*b]   <= AW'($signed(corner_in[CPB*b][2*CW-1:CW]))
                                - AW'($signed(corner_in[CPB*b+1][2*CW-1:CW]));
                axy_reg[2*b]   <= AW'($signed(corner_in[CPB*b][CW-1:0]))
                                - AW'($signed(corner_in[CPB*b+1][CW-1:0]));
                axx_reg[2*b+1] <= AW'($signed(corner_in[CPB*b+2][2*CW-1:CW]))
                                - AW'($signed(corner_in[CPB*b+1][2*CW-1:CW]));
                axy_reg[2*b+1] <= AW'($signed(corner_in[CPB*b+2][CW-1:0]))
                                - AW'($signed(corner_in[CPB*b+1][CW-1:0]));
            end
        end
    end

    // stage 1: products
    always_ff @(posedge aclk) begin
        if (stage_en[1]) begin
            for (int k = 0; k < NA; k++) begin
                for (int c = 0; c < NC; c++) begin
                    prodx_reg[k][c] <= PW'(axx_reg[k]) * PW'(xs_reg[c]);
                    prody_reg[k][c] <= PW'(axy_reg[k]) * PW'(ys_reg[c]);
                end
            end
        end
    end

    // stage 2: projections
    always_ff @(posedge aclk) begin
        if (stage_en[2]) begin
            for (int k = 0; k < NA; k++) begin
                for (int c = 0; c < NC; c++) begin
                    proj_reg[k][c] <= SW'(prodx_reg[k][c]) + SW'(prody_reg[k][c]);
                end
            end
        end
    end

    // stage 3: min/max of corner pairs
    always_ff @(posedge aclk) begin
        if (stage_en[3]) begin
            for (int k = 0; k < NA; k++) begin
                for (int b = 0; b < NB; b++) begin
                    for (int p = 0; p < 2; p++) begin
                        if (proj_reg[k][CPB*b+2*p+1] < proj_reg[k][CPB*b+2*p]) begin
                            pmin_reg[k][b][p] <= proj_reg[k][CPB*b+2*p+1];
                            pmax_reg[k][b][p] <= proj_reg[k][CPB*b+2*p];
                        end else begin
                            pmin_reg[k][b][p] <= proj_reg[k][CPB*b+2*p];
                            pmax_reg[k][b][p] <= proj_reg[k][CPB*b+2*p+1];
                        end
                    end
                end
            end
        end
    end

    // stage 4: interval per box and axis
    always_ff @(posedge aclk) begin
        if (stage_en[4]) begin
            for (int k = 0; k < NA; k++) begin
                for (int b = 0; b < NB; b++) begin
                    bmin_reg[k][b] <= (pmin_reg[k][b][1] < pmin_reg[k][b][0]) ?
                                      pmin_reg[k][b][1] : pmin_reg[k][b][0];
                    bmax_reg[k][b] <= (pmax_reg[k][b][0] < pmax_reg[k][b][1]) ?
                                      pmax_reg[k][b][1] : pmax_reg[k][b][0];
                end
            end
        end
    end

    // stage 5: closed intervals must meet on every axis
    always_comb begin
        overlap_next = 1'b1;
        for (int k = 0; k < NA; k++) begin
            if ((bmax_reg[k][0] < bmin_reg[k][1]) || (bmax_reg[k][1] < bmin_reg[k][0])) begin
                overlap_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[LAST]) begin
            overlap_reg <= overlap_next;
        end
    end

    `BBSAT_ASSERT_NXT(a_fill, aclk, aresetn, s_valid && s_ready, valid_reg[0], "accepted transaction did not enter stage 0")
    `BBSAT_ASSERT_IMP(a_full, aclk, aresetn, !s_ready, ($countones(valid_reg) == BBSAT_PIPE_STAGES) && !m_ready, "input stalled while pipeline has room")
    `BBSAT_ASSERT_NXT(a_hold, aclk, aresetn, valid_reg[4] && !stage_en[4], valid_reg[4] && $stable(bmin_reg[0][0]) && $stable(bmax_reg[0][0]), "stalled stage 4 lost or changed its transaction")

endmodule
